// ----- sv/arpr_pkg.sv -----
package arpr_pkg;

   // widths fixed by the frame format
   localparam int MAC_W       = 48;
   localparam int IP_W        = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_MAC = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_IP  = 2'd1;

   // frame constants
   localparam logic [15:0] ARP_ETYPE     = 16'h0806;
   localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [15:0] OPER_REQUEST  = 16'h0001;
   localparam logic [15:0] OPER_REPLY    = 16'h0002;
   localparam logic [15:0] HTYPE_ETH     = 16'h0001;
   localparam logic [7:0]  HLEN_ETH      = 8'd6;
   localparam logic [7:0]  PLEN_IPV4     = 8'd4;

   // byte positions in a received request
   localparam int POS_ETYPE      = 12;
   localparam int POS_OPER       = 20;
   localparam int POS_SENDER_MAC = 22;
   localparam int POS_SENDER_IP  = 28;
   localparam int POS_TARGET_IP  = 38;
   localparam int ARP_MIN_BYTES  = 42;

   // reply index width covers every allowed reply length (up to 128)
   localparam int RIDX_W = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } arpr_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } arpr_rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0] peer_mac;
      logic [IP_W-1:0]  peer_ip;
   } arpr_job_type;

   typedef struct packed {
      logic         valid;
      arpr_job_type job;
   } arpr_push_type;

   typedef struct packed {
      logic         valid;
      arpr_job_type job;
   } arpr_head_type;

   // byte idx of the reply frame, in wire order
   function automatic logic [7:0] reply_byte(input logic [RIDX_W-1:0] idx,
                                             input logic [MAC_W-1:0] pm,
                                             input logic [MAC_W-1:0] lm,
                                             input logic [IP_W-1:0]  lip,
                                             input logic [IP_W-1:0]  pip);
      int k;
      logic [7:0] b;
      k = int'(idx);
      b = '0;
      if (k < 6) begin
         b = pm[8*(5-k) +: 8];
      end else if (k < 12) begin
         b = lm[8*(11-k) +: 8];
      end else if (k < 22) begin
         case (k)
            12:      b = ARP_ETYPE[15:8];
            13:      b = ARP_ETYPE[7:0];
            14:      b = HTYPE_ETH[15:8];
            15:      b = HTYPE_ETH[7:0];
            16:      b = PTYPE_IPV4[15:8];
            17:      b = PTYPE_IPV4[7:0];
            18:      b = HLEN_ETH;
            19:      b = PLEN_IPV4;
            20:      b = OPER_REPLY[15:8];
            default: b = OPER_REPLY[7:0];
         endcase
      end else if (k < 28) begin
         b = lm[8*(27-k) +: 8];
      end else if (k < 32) begin
         b = lip[8*(31-k) +: 8];
      end else if (k < 38) begin
         b = pm[8*(37-k) +: 8];
      end else if (k < 42) begin
         b = pip[8*(41-k) +: 8];
      end
      return b;
   endfunction

endpackage

// ----- sv/arpr_front.sv -----
module arpr_front #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  arpr_pkg::arpr_req_type      item,
   input  logic [arpr_pkg::IP_W-1:0]   local_ip,
   output arpr_pkg::arpr_push_type     push
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES);

   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         ok_ff, ok_in;
   logic [arpr_pkg::MAC_W-1:0]   mac_ff, mac_in;
   logic [arpr_pkg::IP_W-1:0]    ip_ff, ip_in;
   logic                         ok_now;

   always_comb begin
      ok_now = ok_ff;
      mac_in = mac_ff;
      ip_in  = ip_ff;
      for (int k = 0; k < 2; k++) begin
         if (cnt_ff == CNT_W'(arpr_pkg::POS_ETYPE + k) &&
             item.rx_byte != arpr_pkg::ARP_ETYPE[8*(1-k) +: 8]) begin
            ok_now = 1'b0;
         end
         if (cnt_ff == CNT_W'(arpr_pkg::POS_OPER + k) &&
             item.rx_byte != arpr_pkg::OPER_REQUEST[8*(1-k) +: 8]) begin
            ok_now = 1'b0;
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (cnt_ff == CNT_W'(arpr_pkg::POS_TARGET_IP + k) &&
             item.rx_byte != local_ip[8*(3-k) +: 8]) begin
            ok_now = 1'b0;
         end
         if (cnt_ff == CNT_W'(arpr_pkg::POS_SENDER_IP + k)) begin
            ip_in[8*(3-k) +: 8] = item.rx_byte;
         end
      end
      for (int k = 0; k < 6; k++) begin
         if (cnt_ff == CNT_W'(arpr_pkg::POS_SENDER_MAC + k)) begin
            mac_in[8*(5-k) +: 8] = item.rx_byte;
         end
      end

      cnt_in = cnt_ff;
      ok_in  = ok_now;
      if (item.rx_last) begin
         cnt_in = '0;
         ok_in  = 1'b1;
      end else if (cnt_ff != CNT_W'(MAX_FRAME_BYTES - 1)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      push.valid        = accept && item.rx_last && ok_now &&
                          (cnt_ff >= CNT_W'(arpr_pkg::ARP_MIN_BYTES - 1));
      push.job.peer_mac = mac_in;
      push.job.peer_ip  = ip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ok_ff  <= 1'b1;
         mac_ff <= '0;
         ip_ff  <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         ok_ff  <= ok_in;
         mac_ff <= mac_in;
         ip_ff  <= ip_in;
      end
   end

endmodule

// ----- sv/arpr_queue.sv -----
module arpr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  arpr_pkg::arpr_push_type  push,
   input  logic                     pop,
   output arpr_pkg::arpr_head_type  head,
   output logic                     full
);

   localparam int CNT_W = $clog2(arpr_pkg::QUEUE_DEPTH + 1);

   arpr_pkg::arpr_job_type            slot_ff [arpr_pkg::QUEUE_DEPTH];
   logic [arpr_pkg::QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push.valid ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push.valid) - CNT_W'(do_pop);
      full   = (cnt_ff == CNT_W'(arpr_pkg::QUEUE_DEPTH));
      head.valid = (cnt_ff != '0);
      head.job   = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.job;
      end
   end

endmodule

// ----- sv/arpr_back.sv -----
module arpr_back #(
   parameter int REPLY_BYTES = 60
) (
   input  logic                        clock,
   input  logic                        reset,
   input  arpr_pkg::arpr_head_type     head,
   input  logic [arpr_pkg::MAC_W-1:0]  local_mac,
   input  logic [arpr_pkg::IP_W-1:0]   local_ip,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output arpr_pkg::arpr_rsp_type      rsp_item
);

   localparam int IDX_W = $clog2(REPLY_BYTES);

   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     valid_ff, valid_in;
   arpr_pkg::arpr_rsp_type   rsp_ff, rsp_in;
   logic                     load, at_end;

   always_comb begin
      load   = head.valid && (!valid_ff || rsp_ready);
      at_end = (idx_ff == IDX_W'(REPLY_BYTES - 1));
      pop    = load && at_end;

      idx_in = idx_ff;
      if (load) begin
         idx_in = at_end ? '0 : idx_ff + IDX_W'(1);
      end

      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

      rsp_in.tx_byte = arpr_pkg::reply_byte(arpr_pkg::RIDX_W'(idx_ff), head.job.peer_mac,
                                            local_mac, local_ip, head.job.peer_ip);
      rsp_in.tx_last = at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- sv/arp_request_responder_unit.sv -----
// Request bytes: one per cycle; req_ready drops only while two replies are still queued.
// Reply: REPLY_BYTES items, one per cycle while rsp_ready is high, set by the back-end index counter.
// With the back end idle, the reply job is written into the queue as the last request byte is taken,
// and the first reply byte is then registered from the queue head into the output register.
// A queue of two replies decouples the back end from the front end.
// Synchronous active-high reset clears the byte counter, sets the check flag, clears the queue,
// the output stage valid and the local MAC/IP registers (both to zero).
module arp_request_responder_unit #(
   parameter int MAX_FRAME_BYTES = 2048,
   parameter int REPLY_BYTES     = 60
) (
   input  logic                                clock,
   input  logic                                reset,
   // received frame bytes
   input  logic                                req_valid,
   output logic                                req_ready,
   input  arpr_pkg::arpr_req_type              req_item,
   // reply frame bytes
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output arpr_pkg::arpr_rsp_type              rsp_item,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arpr_pkg::CSR_DATA_W-1:0]     csr_data
);

   // station address registers
   logic [arpr_pkg::MAC_W-1:0]  mac_ff;
   logic [arpr_pkg::IP_W-1:0]   ip_ff;

   arpr_pkg::arpr_push_type     push;
   arpr_pkg::arpr_head_type     head;
   logic                        pop;
   logic                        full;
   logic                        req_accept;

   // registers are always writable; writing only while idle is up to the user, unenforced by the block
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0;
         ip_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            arpr_pkg::CSR_LOCAL_MAC: mac_ff <= csr_data[arpr_pkg::MAC_W-1:0];
            arpr_pkg::CSR_LOCAL_IP:  ip_ff  <= csr_data[arpr_pkg::IP_W-1:0];
            default: ;
         endcase
      end
   end

   // front end holds off only when no queue slot is free for a possible reply
   assign req_ready  = !full;
   assign req_accept = req_valid && req_ready;

   // front: byte counter, checks, sender capture; pushes a reply job on a good last byte
   arpr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .item     (req_item),
      .local_ip (ip_ff),
      .push     (push)
   );

   // job queue: snapshot of the requester's addresses per pending reply
   arpr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   // back: walks the reply bytes into the output register
   arpr_back #(
      .REPLY_BYTES(REPLY_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .local_mac (mac_ff),
      .local_ip  (ip_ff),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- sv/arpr_checker.sv -----
module arpr_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input arpr_pkg::arpr_rsp_type  rsp_item,
   input logic                    csr_ready
);

   // stalled reply item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("reply item changed while stalled");

   // reply bytes stream without gaps inside a frame
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.tx_last |=> rsp_valid)
      else $error("gap inside reply frame");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("reply valid after reset");

   // register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port stalled");

endmodule

bind arp_request_responder_unit arpr_checker u_arpr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item),
   .csr_ready (csr_ready)
);
